[rtl/core/heat_stencil_rhs_3d_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the heat stencil block.
// Each macro checks one implication on the rising clock edge, with reset
// masking the check.
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_RHS_3D_ASSERT_SVH
`define HEAT_STENCIL_RHS_3D_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heat stencil: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heat stencil: next-cycle check failed");

`endif

[rtl/core/hsr3d_pkg.sv]
// ----------------------------------------------------------------------------
// hsr3d_pkg
// Shared types, widths, codes and helpers for the 3D heat stencil block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsr3d_pkg;

    // Field widths.
    localparam int COORD_W    = 4;
    localparam int VAL_W      = 32;
    localparam int WEIGHT_W   = 20;
    localparam int SIZE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Internal widths. Grid sizes and neighbor coordinates fit in DIM_W bits, at most 127.
    localparam int DIM_W  = 7;
    localparam int FRAC_W = 16;
    localparam int SUM_W  = VAL_W + 3;
    localparam int LAP_W  = VAL_W + 4;
    localparam int HALF_W = LAP_W / 2;
    localparam int PROD_W = WEIGHT_W + 1 + HALF_W + 1;
    localparam int T_W    = 60;
    localparam int B_W    = T_W - FRAC_W;

    // Default store dimensions.
    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_MAX_DEPTH  = 16;
    localparam int DEF_MAX_HEIGHT = 16;

    // Register reset values and limits.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = '0;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(16);
    localparam int                  MIN_SIZE     = 2;

    // Saturation bounds.
    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(3);

    // Request operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Stencil taps in the order they are read from the grid memory.
    typedef enum logic [2:0] {
        TAP_CENTER,
        TAP_XLO,
        TAP_XHI,
        TAP_YLO,
        TAP_YHI,
        TAP_ZLO,
        TAP_ZHI
    } t_tap;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic wr;
        logic rd;
        t_tap tap;
        logic col;
        logic col_center;
        logic lap;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath about the request on the input port.
    typedef struct packed {
        logic is_query;
        logic oor;
    } t_dp_stat;

    // Limit a grid size register to the range the store supports.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] size,
                                                   input int unsigned max_size);
        logic [DIM_W-1:0] v;
        logic [DIM_W-1:0] lim;
        v   = DIM_W'(size);
        lim = DIM_W'(max_size);
        if (v < DIM_W'(MIN_SIZE)) begin
            clamp_dim = DIM_W'(MIN_SIZE);
        end else if (v > lim) begin
            clamp_dim = lim;
        end else begin
            clamp_dim = v;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/hsr3d_ram.sv]
// ----------------------------------------------------------------------------
// hsr3d_ram
// Generic single-port RAM with a write and a read sharing one address, and
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr3d_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port and registered read port share the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/hsr3d_dp.sv]
// ----------------------------------------------------------------------------
// hsr3d_dp
// Datapath: configuration registers, grid memory, tap address generation,
// neighbor accumulation, shared multiplier, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr3d_dp #(
    parameter int MAX_WIDTH  = hsr3d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_DEPTH  = hsr3d_pkg::DEF_MAX_DEPTH,
    parameter int MAX_HEIGHT = hsr3d_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [hsr3d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hsr3d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_operation,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_x,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_y,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_z,
    input  wire logic signed [hsr3d_pkg::VAL_W-1:0]  i_cell_value,
    input  wire hsr3d_pkg::t_dp_cmd                  i_cmd,
    output hsr3d_pkg::t_dp_stat                      o_stat,
    output logic signed [hsr3d_pkg::VAL_W-1:0]       o_rhs_value,
    output logic                                     o_out_of_range
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_DEPTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PLANE       = MAX_WIDTH * MAX_DEPTH;

    localparam int DIM_W  = hsr3d_pkg::DIM_W;
    localparam int VAL_W  = hsr3d_pkg::VAL_W;
    localparam int SUM_W  = hsr3d_pkg::SUM_W;
    localparam int LAP_W  = hsr3d_pkg::LAP_W;
    localparam int HALF_W = hsr3d_pkg::HALF_W;
    localparam int PROD_W = hsr3d_pkg::PROD_W;
    localparam int T_W    = hsr3d_pkg::T_W;
    localparam int B_W    = hsr3d_pkg::B_W;
    localparam int FRAC_W = hsr3d_pkg::FRAC_W;

    // Lower neighbor along one axis, reflected at the low face.
    function automatic logic [DIM_W-1:0] nb_lo(input logic [DIM_W-1:0] pos);
        if (pos == '0) begin
            nb_lo = pos + DIM_W'(1);
        end else begin
            nb_lo = pos - DIM_W'(1);
        end
    endfunction

    // Upper neighbor along one axis, reflected at the high face.
    function automatic logic [DIM_W-1:0] nb_hi(input logic [DIM_W-1:0] pos,
                                               input logic [DIM_W-1:0] size);
        if (pos == size - DIM_W'(1)) begin
            nb_hi = pos - DIM_W'(1);
        end else begin
            nb_hi = pos + DIM_W'(1);
        end
    endfunction

    // Configuration registers.
    logic [hsr3d_pkg::WEIGHT_W-1:0] r_weight;
    logic [hsr3d_pkg::SIZE_W-1:0]   r_grid_w;
    logic [hsr3d_pkg::SIZE_W-1:0]   r_grid_d;
    logic [hsr3d_pkg::SIZE_W-1:0]   r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= hsr3d_pkg::WEIGHT_RESET;
            r_grid_w <= hsr3d_pkg::SIZE_RESET;
            r_grid_d <= hsr3d_pkg::SIZE_RESET;
            r_grid_h <= hsr3d_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hsr3d_pkg::CFG_WEIGHT: r_weight <= i_cfg_data;
                hsr3d_pkg::CFG_WIDTH:  r_grid_w <= i_cfg_data[hsr3d_pkg::SIZE_W-1:0];
                hsr3d_pkg::CFG_DEPTH:  r_grid_d <= i_cfg_data[hsr3d_pkg::SIZE_W-1:0];
                hsr3d_pkg::CFG_HEIGHT: r_grid_h <= i_cfg_data[hsr3d_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid sizes in use and range checks on the incoming request.
    logic [DIM_W-1:0] w_size_x, w_size_y, w_size_z;
    logic [DIM_W-1:0] w_in_x, w_in_y, w_in_z;
    logic             w_in_store;

    assign w_size_x = hsr3d_pkg::clamp_dim(r_grid_w, MAX_WIDTH);
    assign w_size_y = hsr3d_pkg::clamp_dim(r_grid_d, MAX_DEPTH);
    assign w_size_z = hsr3d_pkg::clamp_dim(r_grid_h, MAX_HEIGHT);
    assign w_in_x   = DIM_W'(i_cell_x);
    assign w_in_y   = DIM_W'(i_cell_y);
    assign w_in_z   = DIM_W'(i_cell_z);

    assign o_stat.is_query = (i_operation == hsr3d_pkg::OP_QUERY);
    assign o_stat.oor      = (w_in_x >= w_size_x) || (w_in_y >= w_size_y) ||
                             (w_in_z >= w_size_z);
    assign w_in_store      = (w_in_x < DIM_W'(MAX_WIDTH)) && (w_in_y < DIM_W'(MAX_DEPTH)) &&
                             (w_in_z < DIM_W'(MAX_HEIGHT));

    // Query coordinates and reflected neighbor coordinates, held for the reads.
    logic [DIM_W-1:0] r_cx, r_cy, r_cz;
    logic [DIM_W-1:0] r_xlo, r_xhi, r_ylo, r_yhi, r_zlo, r_zhi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx  <= w_in_x;
            r_cy  <= w_in_y;
            r_cz  <= w_in_z;
            r_xlo <= nb_lo(w_in_x);
            r_xhi <= nb_hi(w_in_x, w_size_x);
            r_ylo <= nb_lo(w_in_y);
            r_yhi <= nb_hi(w_in_y, w_size_y);
            r_zlo <= nb_lo(w_in_z);
            r_zhi <= nb_hi(w_in_z, w_size_z);
        end
    end

    // Pick the coordinates of the current tap, or of the write request.
    logic [DIM_W-1:0] w_ax, w_ay, w_az;
    logic [ADDR_W-1:0] w_addr;

    always_comb begin
        w_ax = r_cx;
        w_ay = r_cy;
        w_az = r_cz;
        if (i_cmd.wr) begin
            w_ax = w_in_x;
            w_ay = w_in_y;
            w_az = w_in_z;
        end else begin
            unique case (i_cmd.tap)
                hsr3d_pkg::TAP_CENTER: ;
                hsr3d_pkg::TAP_XLO:    w_ax = r_xlo;
                hsr3d_pkg::TAP_XHI:    w_ax = r_xhi;
                hsr3d_pkg::TAP_YLO:    w_ay = r_ylo;
                hsr3d_pkg::TAP_YHI:    w_ay = r_yhi;
                hsr3d_pkg::TAP_ZLO:    w_az = r_zlo;
                hsr3d_pkg::TAP_ZHI:    w_az = r_zhi;
                default: ;
            endcase
        end
    end

    assign w_addr = ADDR_W'(32'(w_ax) + 32'(w_ay) * 32'(MAX_WIDTH) + 32'(w_az) * 32'(PLANE));

    // Grid memory.
    logic [VAL_W-1:0] w_rdata;

    hsr3d_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (STORE_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && w_in_store),
        .i_re    (i_cmd.rd),
        .i_addr  (w_addr),
        .i_wdata (i_cell_value),
        .o_rdata (w_rdata)
    );

    // Collect the center value and the sum of the six neighbors.
    logic signed [VAL_W-1:0] w_rd_s;
    logic signed [VAL_W-1:0] r_u;
    logic signed [SUM_W-1:0] r_sum;

    assign w_rd_s = w_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sum <= '0;
        end else if (i_cmd.col) begin
            if (i_cmd.col_center) begin
                r_u <= w_rd_s;
            end else begin
                r_sum <= r_sum + SUM_W'(w_rd_s);
            end
        end
    end

    // Laplacian: neighbor sum minus six times the center.
    logic signed [LAP_W-1:0] r_lap;
    logic signed [LAP_W-1:0] w_u_ext;

    assign w_u_ext = LAP_W'(r_u);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lap) begin
            r_lap <= LAP_W'(r_sum) - (w_u_ext <<< 2) - (w_u_ext <<< 1);
        end
    end

    // One multiplier, used for the low half and then the high half of the
    // Laplacian.
    logic signed [hsr3d_pkg::WEIGHT_W:0] w_mul_a;
    logic signed [HALF_W:0]              w_mul_b;
    logic signed [PROD_W-1:0]            w_prod;
    logic signed [PROD_W-1:0]            r_plo;
    logic signed [PROD_W-1:0]            r_phi;

    assign w_mul_a = {1'b0, r_weight};
    assign w_mul_b = i_cmd.mul_lo ? {1'b0, r_lap[HALF_W-1:0]}
                                  : {r_lap[LAP_W-1], r_lap[LAP_W-1:HALF_W]};
    assign w_prod  = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= w_prod;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_prod;
        end
    end

    // Final sum, floor shift and saturation to the result width.
    logic signed [T_W-1:0] w_t;
    logic signed [B_W-1:0] w_b;
    logic                  w_over;
    logic                  w_under;
    logic [VAL_W-1:0]      w_sat;

    assign w_t     = (T_W'(r_u) <<< FRAC_W) + (T_W'(r_phi) <<< HALF_W) + T_W'(r_plo);
    assign w_b     = B_W'(w_t >>> FRAC_W);
    assign w_over  = !w_b[B_W-1] && (|w_b[B_W-2:VAL_W-1]);
    assign w_under = w_b[B_W-1] && !(&w_b[B_W-2:VAL_W-1]);

    always_comb begin
        priority if (w_over) begin
            w_sat = hsr3d_pkg::SAT_MAX;
        end else if (w_under) begin
            w_sat = hsr3d_pkg::SAT_MIN;
        end else begin
            w_sat = w_b[VAL_W-1:0];
        end
    end

    // Result register and output register.
    logic [VAL_W-1:0] r_res;
    logic             r_oor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res <= '0;
            r_oor <= o_stat.oor;
        end else if (i_cmd.sum) begin
            r_res <= w_sat;
        end
        if (i_cmd.out_load) begin
            o_rhs_value    <= r_res;
            o_out_of_range <= r_oor;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hsr3d_ctrl.sv]
// ----------------------------------------------------------------------------
// hsr3d_ctrl
// Controller: accepts requests, sequences the seven grid reads and the
// arithmetic steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heat_stencil_rhs_3d_assert.svh"

module hsr3d_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    input  wire hsr3d_pkg::t_dp_stat  i_stat,
    output hsr3d_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_LAP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    hsr3d_pkg::t_tap   r_tap, n_tap;
    logic              r_out_valid, n_out_valid;
    logic              w_slot_free;

    // The output register can take a new result when empty or being emptied.
    assign w_slot_free = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        o_cmd       = '0;
        o_cmd.tap   = r_tap;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_stat.is_query) begin
                        o_cmd.wr = 1'b1;
                    end else if (i_stat.oor) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                        n_tap   = hsr3d_pkg::TAP_CENTER;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd         = 1'b1;
                o_cmd.col        = (r_tap != hsr3d_pkg::TAP_CENTER);
                o_cmd.col_center = (r_tap == hsr3d_pkg::TAP_XLO);
                if (r_tap == hsr3d_pkg::TAP_ZHI) begin
                    n_state = ST_LAST;
                end else begin
                    n_tap = hsr3d_pkg::t_tap'(r_tap + 3'd1);
                end
            end
            ST_LAST: begin
                o_cmd.col = 1'b1;
                n_state   = ST_LAP;
            end
            ST_LAP: begin
                o_cmd.lap = 1'b1;
                n_state   = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= hsr3d_pkg::TAP_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
    end

    // A result never overwrites one that is still waiting.
    `HSR_ASSERT_SAME(a_load_slot_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || !i_stall)

    // An in-range query starts its reads with the center cell.
    `HSR_ASSERT_NEXT(a_query_starts_reads, i_clk, i_rst_n, r_state == ST_IDLE && i_valid && i_stat.is_query && !i_stat.oor, r_state == ST_READ && r_tap == hsr3d_pkg::TAP_CENTER)

    // The last neighbor read is followed by its collection step.
    `HSR_ASSERT_NEXT(a_last_read_collects, i_clk, i_rst_n, r_state == ST_READ && r_tap == hsr3d_pkg::TAP_ZHI, r_state == ST_LAST)

endmodule

`default_nettype wire

[rtl/core/heat_stencil_rhs_3d.sv]
// ----------------------------------------------------------------------------
// heat_stencil_rhs_3d
// Seven-point 3D heat stencil with reflecting faces: stores grid cells and
// returns b = u + c*(S - 6u) for a queried cell, floored and saturated.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         i_valid / o_stall  i_operation, i_cell_x/y/z, i_cell_value
//  result    out        o_valid / i_stall  o_rhs_value, o_out_of_range
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
//  A cell write is done in the accepting cycle; the next request can follow at once.
//  An in-range query is accepted, then makes seven reads of the
//  single-port grid memory, a collection step, the Laplacian, two multiply
//  halves on one shared multiplier, the final sum and the hand-off to the
//  output register. An out-of-range query goes straight to the hand-off.
//  Reset is synchronous and active low; the grid memory is not cleared.
//  A waiting result stalls only the hand-off step of the next query.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_stencil_rhs_3d #(
    parameter int MAX_WIDTH  = hsr3d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_DEPTH  = hsr3d_pkg::DEF_MAX_DEPTH,
    parameter int MAX_HEIGHT = hsr3d_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [hsr3d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hsr3d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_operation,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_x,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_y,
    input  wire logic [hsr3d_pkg::COORD_W-1:0]       i_cell_z,
    input  wire logic signed [hsr3d_pkg::VAL_W-1:0]  i_cell_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [hsr3d_pkg::VAL_W-1:0]       o_rhs_value,
    output logic                                     o_out_of_range
);

    hsr3d_pkg::t_dp_cmd  w_cmd;
    hsr3d_pkg::t_dp_stat w_stat;

    // Sequencer.
    hsr3d_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Storage and arithmetic.
    hsr3d_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_z       (i_cell_z),
        .i_cell_value   (i_cell_value),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_rhs_value    (o_rhs_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D heat stencil block. Requests come from a
// queue that is filled phase by phase. Every accepted request updates a
// shadow grid, or produces an expected right-hand-side result. Results are
// compared in order against those expectations. Both handshakes idle and
// stall at random, with long receiver hold-offs to fill the pipeline.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int COORD_W    = hsr3d_pkg::COORD_W;
    localparam int VAL_W      = hsr3d_pkg::VAL_W;
    localparam int CFG_IDX_W  = hsr3d_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = hsr3d_pkg::CFG_DATA_W;
    localparam int WEIGHT_W   = hsr3d_pkg::WEIGHT_W;
    localparam int SIZE_W     = hsr3d_pkg::SIZE_W;
    localparam int FRAC_W     = hsr3d_pkg::FRAC_W;
    localparam int MIN_SIZE   = hsr3d_pkg::MIN_SIZE;

    localparam int GRID_X        = hsr3d_pkg::DEF_MAX_WIDTH;
    localparam int GRID_Y        = hsr3d_pkg::DEF_MAX_DEPTH;
    localparam int GRID_Z        = hsr3d_pkg::DEF_MAX_HEIGHT;
    localparam int CELLS         = GRID_X * GRID_Y * GRID_Z;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef struct {
        logic                    op;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [COORD_W-1:0]      z;
        logic signed [VAL_W-1:0] value;
    } t_cell_req;

    typedef struct {
        logic signed [VAL_W-1:0] rhs;
        logic                    oor;
    } t_rhs_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    // DUT inputs, all known from time zero.
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;
    logic                    i_valid        = 1'b0;
    logic                    i_operation    = hsr3d_pkg::OP_WRITE;
    logic [COORD_W-1:0]      i_cell_x       = '0;
    logic [COORD_W-1:0]      i_cell_y       = '0;
    logic [COORD_W-1:0]      i_cell_z       = '0;
    logic signed [VAL_W-1:0] i_cell_value   = '0;
    logic                    i_stall        = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_rhs_value;
    logic                    o_out_of_range;

    // Shadow configuration and grid contents as seen by accepted requests.
    logic [WEIGHT_W-1:0]     weight_reg = hsr3d_pkg::WEIGHT_RESET;
    logic [SIZE_W-1:0]       size_x_reg = hsr3d_pkg::SIZE_RESET;
    logic [SIZE_W-1:0]       size_y_reg = hsr3d_pkg::SIZE_RESET;
    logic [SIZE_W-1:0]       size_z_reg = hsr3d_pkg::SIZE_RESET;
    logic signed [VAL_W-1:0] cell_mem [0:CELLS-1];
    bit                      cell_written [0:CELLS-1];

    t_cell_req               cell_requests[$];
    t_rhs_result             rhs_expected[$];
    int                      mismatches  = 0;
    logic                    hold_toggle = 1'b0;

    // Sender burst state and receiver stall state.
    int                      burst_left;
    int                      gap_left;
    int                      hold_left;
    int                      mode_left;
    logic                    hold_seen;
    t_stall_mode             stall_mode;

    heat_stencil_rhs_3d uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_z       (i_cell_z),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rhs_value    (o_rhs_value),
        .o_out_of_range (o_out_of_range)
    );

    // Clock generation.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Grid size register as used by the block: limited to [2, 16].
    function automatic int size_in_use(input logic [SIZE_W-1:0] r, input int lim);
        if (r < MIN_SIZE) begin
            return MIN_SIZE;
        end else if (r > lim) begin
            return lim;
        end
        return r;
    endfunction

    function automatic int addr_of(input int x, input int y, input int z);
        return x + y * GRID_X + z * GRID_X * GRID_Y;
    endfunction

    function automatic longint cell_at(input int x, input int y, input int z);
        return longint'(cell_mem[addr_of(x, y, z)]);
    endfunction

    // Neighbor positions along one axis; a face mirrors the inner neighbor.
    function automatic void reflect(input int pos, input int size,
                                    output int lo, output int hi);
        lo = pos - 1;
        hi = pos + 1;
        if (pos == 0) begin
            lo = hi;
        end else if (pos == size - 1) begin
            hi = lo;
        end
    endfunction

    // Expected result for a query: b = floor((u*2^16 + c*(S - 6u)) / 2^16).
    function automatic t_rhs_result stencil_rhs(input int x, input int y, input int z);
        t_rhs_result r;
        int          w, d, h, xl, xh, yl, yh, zl, zh;
        longint      u, s, lap, t, b;
        w = size_in_use(size_x_reg, GRID_X);
        d = size_in_use(size_y_reg, GRID_Y);
        h = size_in_use(size_z_reg, GRID_Z);
        r.rhs = '0;
        r.oor = 1'b0;
        if (x >= w || y >= d || z >= h) begin
            r.oor = 1'b1;
            return r;
        end
        reflect(x, w, xl, xh);
        reflect(y, d, yl, yh);
        reflect(z, h, zl, zh);
        u   = cell_at(x, y, z);
        s   = cell_at(xl, y, z) + cell_at(xh, y, z) + cell_at(x, yl, z)
            + cell_at(x, yh, z) + cell_at(x, y, zl) + cell_at(x, y, zh);
        lap = s - 6 * u;
        t   = u * 65536 + longint'(weight_reg) * lap;
        b   = t >>> FRAC_W;
        if (b > longint'(32'sh7FFF_FFFF)) begin
            b = longint'(32'sh7FFF_FFFF);
        end else if (b < -longint'(64'h8000_0000)) begin
            b = -longint'(64'h8000_0000);
        end
        r.rhs = b[VAL_W-1:0];
        return r;
    endfunction

    // Cell values weighted toward the extremes and toward small numbers.
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4, 5: return VAL_W'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            default: return $urandom();
        endcase
    endfunction

    // Idle cycles after a burst of requests; often none at all.
    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2: return 0;
            3: return $urandom_range(20, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic push_write(input int x, input int y, input int z,
                              input logic [VAL_W-1:0] v);
        t_cell_req req;
        req.op    = hsr3d_pkg::OP_WRITE;
        req.x     = COORD_W'(x);
        req.y     = COORD_W'(y);
        req.z     = COORD_W'(z);
        req.value = v;
        cell_written[addr_of(x, y, z)] = 1'b1;
        cell_requests.push_back(req);
    endtask

    task automatic fill_cell(input int x, input int y, input int z);
        if (!cell_written[addr_of(x, y, z)]) begin
            push_write(x, y, z, random_value());
        end
    endtask

    // A query in the grid first gets writes for any of its seven taps that
    // were never written, so no unwritten cell is ever read.
    task automatic push_query(input int x, input int y, input int z);
        t_cell_req req;
        int        w, d, h, xl, xh, yl, yh, zl, zh;
        w = size_in_use(size_x_reg, GRID_X);
        d = size_in_use(size_y_reg, GRID_Y);
        h = size_in_use(size_z_reg, GRID_Z);
        if (x < w && y < d && z < h) begin
            reflect(x, w, xl, xh);
            reflect(y, d, yl, yh);
            reflect(z, h, zl, zh);
            fill_cell(x, y, z);
            fill_cell(xl, y, z);
            fill_cell(xh, y, z);
            fill_cell(x, yl, z);
            fill_cell(x, yh, z);
            fill_cell(x, y, zl);
            fill_cell(x, y, zh);
        end
        req.op    = hsr3d_pkg::OP_QUERY;
        req.x     = COORD_W'(x);
        req.y     = COORD_W'(y);
        req.z     = COORD_W'(z);
        req.value = $urandom();
        cell_requests.push_back(req);
    endtask

    // Mostly writes and queries inside the grid, some anywhere in the store.
    task automatic push_random_item();
        int w, d, h;
        w = size_in_use(size_x_reg, GRID_X);
        d = size_in_use(size_y_reg, GRID_Y);
        h = size_in_use(size_z_reg, GRID_Z);
        case ($urandom_range(0, 19))
            0, 1: push_write($urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Y - 1),
                             $urandom_range(0, GRID_Z - 1), random_value());
            2, 3: push_query($urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Y - 1),
                             $urandom_range(0, GRID_Z - 1));
            4, 5, 6, 7, 8, 9, 10: push_write($urandom_range(0, w - 1),
                                             $urandom_range(0, d - 1),
                                             $urandom_range(0, h - 1), random_value());
            default: push_query($urandom_range(0, w - 1), $urandom_range(0, d - 1),
                                $urandom_range(0, h - 1));
        endcase
    endtask

    // Wait until every request is sent and every result is back, then let
    // the pipeline settle.
    task automatic wait_idle();
        while (cell_requests.size() != 0 || i_valid || rhs_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            hsr3d_pkg::CFG_WEIGHT: weight_reg = data[WEIGHT_W-1:0];
            hsr3d_pkg::CFG_WIDTH:  size_x_reg = data[SIZE_W-1:0];
            hsr3d_pkg::CFG_DEPTH:  size_y_reg = data[SIZE_W-1:0];
            default:               size_z_reg = data[SIZE_W-1:0];
        endcase
    endtask

    // Program all four registers while the block is idle. Unused upper data
    // bits of the size registers carry random noise.
    task automatic set_grid(input logic [WEIGHT_W-1:0] weight,
                            input int w, input int d, input int h);
        wait_idle();
        cfg_write(hsr3d_pkg::CFG_WEIGHT, weight);
        cfg_write(hsr3d_pkg::CFG_WIDTH,  {15'($urandom()), SIZE_W'(w)});
        cfg_write(hsr3d_pkg::CFG_DEPTH,  {15'($urandom()), SIZE_W'(d)});
        cfg_write(hsr3d_pkg::CFG_HEIGHT, {15'($urandom()), SIZE_W'(h)});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [WEIGHT_W-1:0] weight, input int w,
                             input int d, input int h, input int n, input bit hold);
        set_grid(weight, w, d, h);
        for (int i = 0; i < n; i++) begin
            push_random_item();
        end
        if (hold) begin
            @(posedge i_clk);
            hold_toggle <= ~hold_toggle;
        end
        wait_idle();
    endtask

    // Request driver: bursts of requests from the queue with random gaps.
    always @(posedge i_clk) begin : drive_requests
        t_cell_req nxt;
        logic      fire;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            fire = i_valid && !o_stall;
            if (fire) begin
                if (i_operation == hsr3d_pkg::OP_WRITE) begin
                    cell_mem[addr_of(int'(i_cell_x), int'(i_cell_y), int'(i_cell_z))] =
                        i_cell_value;
                end else begin
                    rhs_expected.push_back(stencil_rhs(int'(i_cell_x), int'(i_cell_y),
                                                       int'(i_cell_z)));
                end
            end
            if (fire || !i_valid) begin
                if (gap_left != 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (cell_requests.size() != 0) begin
                    nxt = cell_requests.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= nxt.op;
                    i_cell_x     <= nxt.x;
                    i_cell_y     <= nxt.y;
                    i_cell_z     <= nxt.z;
                    i_cell_value <= nxt.value;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= pick_gap();
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall pattern: random modes, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            hold_left  <= 0;
            hold_seen  <= 1'b0;
            mode_left  <= 0;
            stall_mode <= STALL_NONE;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(8, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= ~i_stall;
            endcase
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_rhs_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rhs_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got rhs %0d oor %0b",
                         $time, o_rhs_value, o_out_of_range);
            end else begin
                want = rhs_expected.pop_front();
                if (o_rhs_value !== want.rhs) begin
                    mismatches++;
                    $display("%0t: rhs_value expected %0d, got %0d",
                             $time, want.rhs, o_rhs_value);
                end
                if (o_out_of_range !== want.oor) begin
                    mismatches++;
                    $display("%0t: out_of_range expected %0b, got %0b",
                             $time, want.oor, o_out_of_range);
                end
            end
        end
    end

    // Stimulus sequence. Queries in large grids pull in extra writes for
    // their taps, so the phases stay short to keep the total near 400.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest grid, largest weight: alternating extremes saturate both
        // ways, and every cell sits on three faces.
        set_grid(20'hFFFFF, 2, 2, 2);
        for (int i = 0; i < 8; i++) begin
            push_write(i & 1, (i >> 1) & 1, (i >> 2) & 1,
                       ((i ^ (i >> 1) ^ (i >> 2)) & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        for (int i = 0; i < 8; i++) begin
            push_query(i & 1, (i >> 1) & 1, (i >> 2) & 1);
        end
        // A write to the far corner is stored even outside the grid in use.
        push_write(GRID_X - 1, GRID_Y - 1, GRID_Z - 1, 32'h0001_0000);
        push_query(2, 0, 0);
        push_query(0, 0, GRID_Z - 1);
        push_query(GRID_X - 1, GRID_Y - 1, GRID_Z - 1);
        wait_idle();

        // Random phases over weights and grid shapes, including sizes that
        // the block has to clamp.
        run_phase(20'h00000, 16, 16, 16, 12, 1'b0);
        run_phase(20'h10000, 4, 3, 5, 24, 1'b1);
        run_phase(20'hFFFFF, 2, 16, 2, 24, 1'b0);
        run_phase(WEIGHT_W'($urandom()), 0, 1, 31, 20, 1'b0);
        run_phase(20'h00001, 17, 7, 3, 16, 1'b1);
        run_phase(WEIGHT_W'($urandom_range(0, 20'h3FFFF)), $urandom_range(2, 16),
                  $urandom_range(2, 16), $urandom_range(2, 16), 12, 1'b0);
        run_phase(WEIGHT_W'($urandom()), 16, 16, 16, 16, 1'b0);
        run_phase(20'h08000, 3, 3, 3, 24, 1'b1);

        if (mismatches == 0 && rhs_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
